// ===== sv/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants of the bitmap first-free allocator
// Field widths, request and status codes, and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_W      = 32;   // bits per map word
  localparam int BIT_W       = 5;    // bit index within a map word
  localparam int DEPTH_DEF   = 1024;
  localparam int NUM_W       = 11;   // entry numbers, count, limit register
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [NUM_W-1:0] NUM_MAX     = '1;
  localparam logic [NUM_W-1:0] NUM_ENT_RST = 11'd1024;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // isolate the lowest set bit, then encode the one-hot position
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] iso;
    logic [BIT_W-1:0]  idx;
    iso = v & (~v + 1'b1);
    idx = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (((j >> k) & 1) == 1) begin
          idx[k] = idx[k] | iso[j];
        end
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/bfa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_map_ram: word-wide bitmap store
// One write and one registered read port; a row that was never written
// since reset reads as all free.
// ----------------------------------------------------------------------------
module bfa_map_ram #(
  parameter int WORDS  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [bfa_pkg::WORD_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [bfa_pkg::WORD_W-1:0] wr_data
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  row_vld_r;
  logic [WORD_W-1:0] rdata_r;
  logic              rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= row_vld_r[rd_addr];
    end
  end

  // rows become valid on first write; reset marks every row free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// ===== sv/bitmap_first_free_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit: first-free bitmap allocator
// Allocate takes the lowest free entry below the limit; release frees one.
// ----------------------------------------------------------------------------
// Sequence: allocate goes to S_SCAN, which searches 1 .. ceil(limit/32) 32-bit
//   map words, then to S_DONE; a valid release goes to S_REL, then S_DONE, and
//   a rejected release or a zero-limit allocate goes straight to S_DONE.
// Throughput: one transaction in flight; the map read port scans one word per
//   cycle while in S_SCAN.
// Reset: synchronous, active low; count zero, limit 1024, per-row valid bits
//   mark the whole map free at once (no clearing pass).
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_unit #(
  parameter int DEPTH = bfa_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config: num_entries
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfa_pkg::NUM_W-1:0]       cfg_data,
  // request
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfa_pkg::IN_TDATA_W-1:0]  in_tdata,   // [10:0] entry_number
  input  logic [0:0]                      in_tuser,   // [0] op
  // result
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfa_pkg::OUT_TDATA_W-1:0] out_tdata,  // [10:0] granted_number,
                                                      // [21:11] used_count
  output logic [bfa_pkg::STATUS_W-1:0]    out_tuser   // [1:0] status
);
  import bfa_pkg::*;

  localparam int NWORDS = (DEPTH + WORD_W - 1) / WORD_W;
  localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LIM_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (LIM_W > NUM_W) ? LIM_W : NUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_REL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NUM_W-1:0]       num_ent_r;
  logic [NUM_W-1:0]       count_r, count_nxt;
  logic [WA_W-1:0]        cur_r, cur_nxt;
  logic [BIT_W-1:0]       bitpos_r, bitpos_nxt;
  status_t                status_r, status_nxt;
  logic [NUM_W-1:0]       granted_r, granted_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [STATUS_W-1:0]    out_user_r;

  logic                   in_fire;
  logic [NUM_W-1:0]       in_num;
  logic [NUM_W-1:0]       in_num_m1;
  logic [CMP_W-1:0]       limit_c;
  logic [CMP_W-1:0]       num_ext;
  logic [CMP_W-1:0]       scan_base;
  logic [CMP_W-1:0]       remaining;
  logic [WORD_W-1:0]      valid_mask;
  logic [WORD_W-1:0]      free_bits;
  logic                   found;
  logic                   more;
  logic [BIT_W-1:0]       free_pos;

  logic                   rd_en;
  logic [WA_W-1:0]        rd_addr;
  logic [WORD_W-1:0]      rd_data;
  logic                   wr_en;
  logic [WORD_W-1:0]      wr_data;

  // config is to be written only while idle (the block does not enforce it), so it is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ent_r <= NUM_ENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_ent_r <= cfg_data;
    end
  end

  // active limit is min(num_entries, DEPTH)
  assign num_ext = CMP_W'(num_ent_r);
  assign limit_c = (num_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : num_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_num    = in_tdata[NUM_W-1:0];
  assign in_num_m1 = in_num - 1'b1;

  // search window of the word under test: mask entries at or past the limit
  assign scan_base  = CMP_W'(cur_r) << BIT_W;
  assign remaining  = limit_c - scan_base;
  assign valid_mask = (remaining >= CMP_W'(WORD_W)) ? '1 :
                      ((WORD_W'(1) << remaining[BIT_W-1:0]) - 1'b1);
  assign free_bits  = ~rd_data & valid_mask;
  assign found      = |free_bits;
  assign more       = remaining > CMP_W'(WORD_W);
  assign free_pos   = lowest_one(free_bits);

  // map port control: read ahead one word per scan cycle, write on hit/free
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_r + 1'b1;
    wr_en   = 1'b0;
    wr_data = rd_data | (WORD_W'(1) << free_pos);
    unique case (state_r)
      S_IDLE: begin
        if (in_tuser[0] == OP_ALLOC) begin
          rd_en   = in_fire;
          rd_addr = '0;
        end else begin
          rd_en   = in_fire;
          rd_addr = WA_W'(in_num_m1 >> BIT_W);
        end
      end
      S_SCAN: begin
        rd_en = !found && more;
        wr_en = found;
      end
      S_REL: begin
        wr_en   = 1'b1;
        wr_data = rd_data & ~(WORD_W'(1) << bitpos_r);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    bitpos_nxt  = bitpos_r;
    status_nxt  = status_r;
    granted_nxt = granted_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt  = ST_OK;
          granted_nxt = '0;
          cur_nxt     = '0;
          bitpos_nxt  = in_num_m1[BIT_W-1:0];
          cur_nxt     = (in_tuser[0] == OP_ALLOC) ? '0 : WA_W'(in_num_m1 >> BIT_W);
          if (in_tuser[0] == OP_ALLOC) begin
            // empty limit: nothing to search
            if (limit_c == '0) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (in_num == '0 || CMP_W'(in_num) > limit_c) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_REL;
            end
          end
        end
      end
      S_SCAN: begin
        priority if (found) begin
          granted_nxt = NUM_W'(scan_base + CMP_W'(free_pos) + 1'b1);
          if (count_r != NUM_MAX) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_DONE;
        end else if (more) begin
          cur_nxt = cur_r + 1'b1;
        end else begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end
      end
      S_REL: begin
        // a free entry still lowers the count
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    bitpos_r  <= bitpos_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {(OUT_TDATA_W - 2 * NUM_W)'(0), count_r, granted_r};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  bfa_map_ram #(
    .WORDS  (NWORDS),
    .ADDR_W (WA_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (cur_r),
    .wr_data (wr_data)
  );

  // the scan never reaches a word that starts at or past the limit
  a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_base < limit_c))
    else $error("map scan ran past the active limit");

  // one transaction at a time: never two requests on adjacent edges
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_fire)
    else $error("request accepted while another is in flight");

  // a nonzero grant only comes with an ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[NUM_W-1:0] == '0 || out_tuser == ST_OK))
    else $error("grant reported with a failure status");

endmodule
